// ===== rtl/core/sed_pkg.sv =====
// Shared constants and types of the string escape decoder.
package sed_pkg;

  // Escape decoder modes
  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_BSL     = 4'd1;
  localparam logic [3:0] MODE_HEX_X   = 4'd2;
  localparam logic [3:0] MODE_HEX_U   = 4'd3;
  localparam logic [3:0] MODE_HI_WAIT = 4'd4;
  localparam logic [3:0] MODE_HI_BSL  = 4'd5;
  localparam logic [3:0] MODE_HI_U    = 4'd6;
  localparam logic [3:0] MODE_CR      = 4'd7;

  // Most beats one input byte can cause, end beat included
  localparam int BURST_MAX = 7;
  localparam int CNT_W     = $clog2(BURST_MAX + 1);

  // Characters of the literal body
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_V   = 8'h76;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_U   = 8'h75;

  // Decoded control characters
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_VT  = 8'h0B;
  localparam logic [7:0] CTL_NUL = 8'h00;

  // Surrogate ranges and UTF-8 framing
  localparam logic [15:0] HI_FIRST  = 16'hD800;
  localparam logic [15:0] HI_LAST   = 16'hDBFF;
  localparam logic [15:0] LO_FIRST  = 16'hDC00;
  localparam logic [15:0] LO_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [7:0]  CONT_TAG  = 8'h80;
  localparam logic [7:0]  LEAD2     = 8'hC0;
  localparam logic [7:0]  LEAD3     = 8'hE0;
  localparam logic [7:0]  LEAD4     = 8'hF0;
  localparam logic [5:0]  CONT_MASK = 6'h3F;

  // Result beats of one decoded input byte
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } burst_t;

  // UTF-8 form of one code point
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } utf8_t;

endpackage

// ===== rtl/core/sed_in_if.sv =====
// Input byte channel of the string escape decoder.
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, in_byte, end_mark, input ready);
  modport sink   (input valid, in_byte, end_mark, output ready);
endinterface

// ===== rtl/core/sed_out_if.sv =====
// Result byte channel of the string escape decoder.
interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, out_byte, has_byte, last, input ready);
  modport sink   (input valid, out_byte, has_byte, last, output ready);
endinterface

// ===== rtl/core/sed_step.sv =====
// Escape state machine and single-pass decode of one byte into a burst.
module sed_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  logic [7:0]     in_byte,
  input  logic           end_mark,
  output sed_pkg::burst_t burst
);
  import sed_pkg::*;

  logic [3:0]  mode_r, mode_nxt;
  logic [1:0]  dc_r, dc_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] hs_r, hs_nxt;
  logic [7:0]  held_r [3];
  logic        held_we;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] unit_v;
  logic        unit_hi, unit_lo;
  logic [3:0]  idle_mode;
  logic        idle_raw;
  logic [3:0]  esc_mode;
  logic        esc_raw_en;
  logic [7:0]  esc_raw;

  logic        hi_e, held_e, raw_e, cp_e, end_e;
  logic [7:0]  raw_b;
  logic [20:0] cp;
  utf8_t       hi_enc, cp_enc, c_seg;
  logic [7:0]  ab [6];
  logic [3:0]  n_ab, n_abc;

  function automatic utf8_t utf8_enc(input logic [20:0] v);
    utf8_t r;
    r = '0;
    if (v < 21'h80) begin
      r.count    = 3'd1;
      r.bytes[0] = v[7:0];
    end else if (v < 21'h800) begin
      r.count    = 3'd2;
      r.bytes[0] = LEAD2 | {3'd0, v[10:6]};
      r.bytes[1] = CONT_TAG | {2'd0, v[5:0] & CONT_MASK};
    end else if (v < SUPP_BASE) begin
      r.count    = 3'd3;
      r.bytes[0] = LEAD3 | {4'd0, v[15:12]};
      r.bytes[1] = CONT_TAG | {2'd0, v[11:6]};
      r.bytes[2] = CONT_TAG | {2'd0, v[5:0]};
    end else begin
      r.count    = 3'd4;
      r.bytes[0] = LEAD4 | {5'd0, v[20:18]};
      r.bytes[1] = CONT_TAG | {2'd0, v[17:12]};
      r.bytes[2] = CONT_TAG | {2'd0, v[11:6]};
      r.bytes[3] = CONT_TAG | {2'd0, v[5:0]};
    end
    return r;
  endfunction

  // Hex digit recognition
  always_comb begin
    hex_ok = 1'b0;
    hex_d  = in_byte[3:0];
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_ok = 1'b1;
    end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_ok = 1'b1;
      hex_d  = in_byte[3:0] + 4'd9;
    end
  end

  assign unit_v  = {acc_r[11:0], hex_d};
  assign unit_hi = unit_v inside {[HI_FIRST:HI_LAST]};
  assign unit_lo = unit_v inside {[LO_FIRST:LO_LAST]};

  // Plain body byte and escaped byte, as used from several modes
  always_comb begin
    idle_mode  = (in_byte == CH_BSL) ? MODE_BSL : MODE_IDLE;
    idle_raw   = (in_byte != CH_BSL);
    esc_mode   = MODE_IDLE;
    esc_raw_en = 1'b1;
    esc_raw    = in_byte;
    case (in_byte)
      CH_N:    esc_raw = CH_LF;
      CH_T:    esc_raw = CTL_TAB;
      CH_R:    esc_raw = CH_CR;
      CH_B:    esc_raw = CTL_BS;
      CH_F:    esc_raw = CTL_FF;
      CH_V:    esc_raw = CTL_VT;
      CH_0:    esc_raw = CTL_NUL;
      CH_X: begin
        esc_mode   = MODE_HEX_X;
        esc_raw_en = 1'b0;
      end
      CH_U: begin
        esc_mode   = MODE_HEX_U;
        esc_raw_en = 1'b0;
      end
      CH_LF:   esc_raw_en = 1'b0;
      CH_CR: begin
        esc_mode   = MODE_CR;
        esc_raw_en = 1'b0;
      end
      default: esc_raw = in_byte;
    endcase
  end

  // Next state and the segments to emit: high surrogate, held digits,
  // then one byte or code point, then the end beat
  always_comb begin
    mode_nxt = mode_r;
    dc_nxt   = dc_r;
    acc_nxt  = acc_r;
    hs_nxt   = hs_r;
    held_we  = 1'b0;
    hi_e     = 1'b0;
    held_e   = 1'b0;
    raw_e    = 1'b0;
    raw_b    = in_byte;
    cp_e     = 1'b0;
    cp       = {5'd0, unit_v};
    end_e    = 1'b0;
    if (end_mark) begin
      end_e    = 1'b1;
      hi_e     = (mode_r == MODE_HI_WAIT) || (mode_r == MODE_HI_BSL) ||
                 (mode_r == MODE_HI_U);
      held_e   = (mode_r == MODE_HEX_X) || (mode_r == MODE_HEX_U) ||
                 (mode_r == MODE_HI_U);
      mode_nxt = MODE_IDLE;
      dc_nxt   = '0;
      acc_nxt  = '0;
      hs_nxt   = '0;
    end else begin
      case (mode_r)
        MODE_BSL: begin
          mode_nxt = esc_mode;
          raw_e    = esc_raw_en;
          raw_b    = esc_raw;
          dc_nxt   = '0;
          acc_nxt  = '0;
        end
        MODE_HEX_X, MODE_HEX_U, MODE_HI_U: begin
          if (!hex_ok) begin
            hi_e     = (mode_r == MODE_HI_U);
            held_e   = 1'b1;
            dc_nxt   = '0;
            acc_nxt  = '0;
            mode_nxt = idle_mode;
            raw_e    = idle_raw;
          end else if ((mode_r == MODE_HEX_X) && (dc_r != 2'd0)) begin
            raw_e    = 1'b1;
            raw_b    = {acc_r[3:0], hex_d};
            dc_nxt   = '0;
            acc_nxt  = '0;
            mode_nxt = MODE_IDLE;
          end else if (dc_r != 2'd3) begin
            held_we = 1'b1;
            acc_nxt = unit_v;
            dc_nxt  = dc_r + 2'd1;
          end else begin
            dc_nxt  = '0;
            acc_nxt = '0;
            if ((mode_r == MODE_HI_U) && unit_lo) begin
              // merge the pair into one supplementary code point
              cp_e     = 1'b1;
              cp       = SUPP_BASE + {1'b0, hs_r[9:0], unit_v[9:0]};
              mode_nxt = MODE_IDLE;
            end else begin
              hi_e = (mode_r == MODE_HI_U);
              if (unit_hi) begin
                hs_nxt   = unit_v;
                mode_nxt = MODE_HI_WAIT;
              end else begin
                cp_e     = 1'b1;
                mode_nxt = MODE_IDLE;
              end
            end
          end
        end
        MODE_HI_WAIT: begin
          if (in_byte == CH_BSL) begin
            mode_nxt = MODE_HI_BSL;
          end else begin
            hi_e     = 1'b1;
            mode_nxt = idle_mode;
            raw_e    = idle_raw;
          end
        end
        MODE_HI_BSL: begin
          dc_nxt  = '0;
          acc_nxt = '0;
          if (in_byte == CH_U) begin
            mode_nxt = MODE_HI_U;
          end else begin
            hi_e     = 1'b1;
            mode_nxt = esc_mode;
            raw_e    = esc_raw_en;
            raw_b    = esc_raw;
          end
        end
        MODE_CR: begin
          // swallow the LF of a CRLF continuation
          mode_nxt = MODE_IDLE;
          if (in_byte != CH_LF) begin
            mode_nxt = idle_mode;
            raw_e    = idle_raw;
          end
        end
        default: begin
          mode_nxt = idle_mode;
          raw_e    = idle_raw;
        end
      endcase
    end
  end

  // Assemble the burst
  always_comb begin
    hi_enc = utf8_enc({5'd0, hs_r});
    cp_enc = utf8_enc(cp);
    c_seg  = '0;
    if (raw_e) begin
      c_seg.count    = 3'd1;
      c_seg.bytes[0] = raw_b;
    end else if (cp_e) begin
      c_seg = cp_enc;
    end
    for (int k = 0; k < 3; k++) begin
      ab[k]     = hi_e ? hi_enc.bytes[k] : held_r[k];
      ab[k + 3] = held_r[k];
    end
    n_ab  = (hi_e ? 4'd3 : 4'd0) + (held_e ? {2'd0, dc_r} : 4'd0);
    n_abc = n_ab + {1'b0, c_seg.count};
    burst = '0;
    for (int k = 0; k < BURST_MAX; k++) begin
      if (4'(k) < n_ab) begin
        burst.bytes[k] = ab[k % 6];
      end else if (4'(k) < n_abc) begin
        burst.bytes[k] = c_seg.bytes[2'(4'(k) - n_ab)];
      end
    end
    burst.count = CNT_W'(n_abc + {3'd0, end_e});
    burst.last  = end_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dc_r   <= '0;
      acc_r  <= '0;
      hs_r   <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      dc_r   <= dc_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_we) begin
      held_r[dc_r] <= in_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_digits_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (dc_r != 2'd0) |-> ((mode_r == MODE_HEX_X) || (mode_r == MODE_HEX_U) ||
                        (mode_r == MODE_HI_U)))
    else $error("digit count set outside a hex escape");
  a_accum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (dc_r == 2'd0) |-> (acc_r == 16'd0))
    else $error("code accumulator holds a value with no digits");
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && end_mark) |=> ((mode_r == MODE_IDLE) && (hs_r == 16'd0)))
    else $error("state not cleared after end of literal");
`endif

endmodule

// ===== rtl/core/sed_burst_buf.sv =====
// Result register that holds one burst and hands it out a beat at a time.
module sed_burst_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  sed_pkg::burst_t burst,
  output logic            free,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            last
);
  import sed_pkg::*;

  logic [BURST_MAX-1:0][7:0] bytes_r;
  logic                      last_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          ptr_r;
  logic                      pop;
  logic                      at_tail;

  assign out_valid = (ptr_r != cnt_r);
  assign pop       = out_valid && out_ready;
  assign at_tail   = (CNT_W'(ptr_r + 1'b1) == cnt_r);
  assign free      = !out_valid || (pop && at_tail);
  assign last      = last_r && at_tail;
  assign has_byte  = !(last_r && at_tail);

  always_comb begin
    out_byte = '0;
    for (int k = 0; k < BURST_MAX; k++) begin
      if (ptr_r == CNT_W'(k)) begin
        out_byte = bytes_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (load) begin
      cnt_r <= burst.count;
      ptr_r <= '0;
    end else if (pop) begin
      ptr_r <= CNT_W'(ptr_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= burst.bytes;
      last_r  <= burst.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(ptr_r > cnt_r))
    else $error("read pointer ran past the burst");
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("burst loaded over beats not yet delivered");
`endif

endmodule

// ===== rtl/core/string_escape_utf8_decoder_unit.sv =====
// Top level of the string escape decoder with UTF-8 output.
//
// in_ch carries the raw bytes of a string literal body, one per beat, and
// then an end beat (end_mark high, in_byte ignored). out_ch carries the
// decoded UTF-8 bytes, one per beat with has_byte high; after the end beat
// comes one beat with has_byte low and last high, and no byte.
// Both channels move a beat on a clock edge with valid and ready high.
// A byte taken into the input register is decoded into the result register
// once that register is free, and its result beats leave from there.
// Throughput: one input beat per cycle while each byte yields at most one
// result beat and out_ch is ready. A byte that yields more beats (up to
// seven, e.g. a surrogate escape or a flushed failed escape) holds the
// result register until its last beat leaves, and the input waits for it.
// One input beat waits in the input register while the result register
// drains, so in_ch.ready stays high whenever that register is empty.
// Reset (rst_n low, synchronous) returns the decoder to plain text with no
// escape pending and empties both registers. When out_ch stalls, the
// current beat holds and the input side fills and then drops ready.
module string_escape_utf8_decoder_unit (
  input  logic      clk,
  input  logic      rst_n,
  sed_in_if.sink    in_ch,
  sed_out_if.source out_ch
);
  import sed_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       end_r;
  logic       free;
  logic       advance;
  logic       in_take;
  burst_t     burst;

  // Decode the held beat as soon as the result register can take its burst
  assign advance     = in_vld_r && free;
  assign in_ch.ready = !in_vld_r || free;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.in_byte;
      end_r     <= in_ch.end_mark;
    end
  end

  // Escape state and burst assembly
  sed_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_byte  (in_byte_r),
    .end_mark (end_r),
    .burst    (burst)
  );

  // Result register: serialize the burst onto out_ch
  sed_burst_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .burst     (burst),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .has_byte  (out_ch.has_byte),
    .last      (out_ch.last)
  );

`ifndef NO_ASSERTIONS
  a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !free) |=> (in_vld_r && $stable(in_byte_r) && $stable(end_r)))
    else $error("input beat lost before decode");
`endif

endmodule
